// ===== rtl/core/tpcs_pkg.sv =====
// Package of the tuner PLL command sequencer: field widths, byte constants,
// the band threshold table and the per-byte transfer tags.
// It depends on nothing and is compiled first.
package tpcs_pkg;

    localparam int FREQ_W   = 22;
    localparam int RATE_W   = 26;
    localparam int CUTOFF_W = 16;
    localparam int CFG_IDX_W = 2;
    localparam int SEQ_LEN  = 8;
    localparam int IDX_W    = 3;

    localparam logic [CFG_IDX_W-1:0] CFG_FINE_STEP   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CUTOFF_RATE = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CUTOFF_KHZ  = 2'd2;

    localparam logic CMD_INIT = 1'b0;
    localparam logic CMD_TUNE = 1'b1;

    localparam logic [IDX_W-1:0] LAST_IDX_INIT = 3'd1;
    localparam logic [IDX_W-1:0] LAST_IDX_TUNE = 3'd7;

    // Reciprocal of 125 scaled by 2**24, rounded down.
    localparam int RECIP_SHIFT = 24;
    localparam logic [17:0] RECIP_125 = 18'd134217;

    localparam logic [7:0] BYTE_PLL_HI    = 8'h40;
    localparam logic [7:0] BYTE_CTRL      = 8'he0;
    localparam logic [7:0] BYTE_LPF_CTRL  = 8'he4;
    localparam logic [7:0] BYTE_BAND_TOP  = 8'hc0;
    localparam logic [7:0] BYTE_INIT_0    = 8'hf8;
    localparam logic [7:0] BYTE_INIT_1    = 8'h04;
    localparam logic [16:0] CUTOFF_FALLBACK = 17'd30000;
    localparam logic [17:0] CUTOFF_ROUND    = 18'd1999;
    localparam logic [8:0]  ROUND_FULL      = 9'd500;
    localparam logic [8:0]  ROUND_HALF      = 9'd250;

    localparam logic [FREQ_W-1:0] BAND_LIMIT [SEQ_LEN] = '{
        22'd986000, 22'd1072000, 22'd1154000, 22'd1291000,
        22'd1447000, 22'd1615000, 22'd1791000, 22'd1972000
    };
    localparam logic [7:0] BAND_CODE [SEQ_LEN] = '{
        8'hb2, 8'hd2, 8'he2, 8'h20, 8'h40, 8'h60, 8'h80, 8'ha0
    };

    typedef struct packed {
        logic                fine_step;
        logic                cutoff_from_rate;
        logic [CUTOFF_W-1:0] cutoff_khz;
    } t_cfg;

    typedef struct packed {
        logic                 command;
        logic [SEQ_LEN*8-1:0] bytes;
    } t_seq;

    typedef struct packed {
        logic [1:0] transfer_number;
        logic       first_of_transfer;
        logic       is_read;
        logic       wait_after;
        logic       last;
    } t_meta;

    function automatic logic [7:0] band_lookup(input logic [FREQ_W-1:0] f);
        logic [7:0] band;
        band = BYTE_BAND_TOP;
        for (int i = SEQ_LEN - 1; i >= 0; i--) begin
            if (f < BAND_LIMIT[i]) begin
                band = BAND_CODE[i];
            end
        end
        return band;
    endfunction

    function automatic t_meta seq_meta(input logic cmd, input logic [IDX_W-1:0] idx);
        t_meta m;
        m = '0;
        if (cmd == CMD_INIT) begin
            m.first_of_transfer = (idx == 3'd0);
            m.last              = (idx == LAST_IDX_INIT);
        end else begin
            unique case (idx)
                3'd0: m.first_of_transfer = 1'b1;
                3'd4: begin
                    m.transfer_number   = 2'd1;
                    m.first_of_transfer = 1'b1;
                    m.wait_after        = 1'b1;
                end
                3'd5: begin
                    m.transfer_number   = 2'd2;
                    m.first_of_transfer = 1'b1;
                end
                3'd6: m.transfer_number = 2'd2;
                3'd7: begin
                    m.transfer_number   = 2'd3;
                    m.first_of_transfer = 1'b1;
                    m.is_read           = 1'b1;
                    m.last              = 1'b1;
                end
                default: m.transfer_number = 2'd0;
            endcase
        end
        return m;
    endfunction

endpackage

// ===== rtl/core/tpcs_if.sv =====
// Channel interfaces of the sequencer: command input, byte output and the
// configuration write channel. They depend on tpcs_pkg for field widths.
interface tpcs_in_if;
    logic                          valid;
    logic                          ready;
    logic                          command;
    logic [tpcs_pkg::FREQ_W-1:0]   frequency_khz;
    logic [tpcs_pkg::RATE_W-1:0]   rate_sps;
    modport source (output valid, command, frequency_khz, rate_sps, input ready);
    modport sink   (input valid, command, frequency_khz, rate_sps, output ready);
endinterface

interface tpcs_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic [1:0] transfer_number;
    logic       first_of_transfer;
    logic       is_read;
    logic       wait_after;
    logic       last;
    modport source (output valid, data_byte, transfer_number, first_of_transfer, is_read,
                    wait_after, last, input ready);
    modport sink   (input valid, data_byte, transfer_number, first_of_transfer, is_read,
                    wait_after, last, output ready);
endinterface

interface tpcs_cfg_if;
    logic                           valid;
    logic                           ready;
    logic [tpcs_pkg::CFG_IDX_W-1:0] index;
    logic [tpcs_pkg::CUTOFF_W-1:0]  data;
    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// ===== rtl/core/tpcs_pipe.sv =====
// Six-stage arithmetic pipeline: divider, band, prescaler remap and low-pass
// code, producing the full byte set of one command. Depends on tpcs_pkg and tpcs_if.
module tpcs_pipe (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  tpcs_pkg::t_cfg  i_cfg,
    tpcs_in_if.sink         i_in,
    output logic            o_valid,
    input  logic            i_ready,
    output tpcs_pkg::t_seq  o_seq
);
    import tpcs_pkg::*;

    logic [5:0] r_v;
    logic [5:0] en;

    logic        r1_cmd;
    logic [7:0]  r1_band;
    logic [20:0] r1_yf;
    logic [22:0] r1_yr;

    logic        r2_cmd;
    logic [7:0]  r2_band;
    logic [20:0] r2_yf;
    logic [22:0] r2_yr;
    logic [14:0] r2_qf;
    logic [16:0] r2_qr;

    logic        r3_cmd;
    logic [7:0]  r3_band;
    logic [14:0] r3_d;
    logic [16:0] r3_cr;

    logic        r4_cmd;
    logic [7:0]  r4_band;
    logic [15:0] r4_word;
    logic [13:0] r4_yc;

    logic        r5_cmd;
    logic [7:0]  r5_band;
    logic [15:0] r5_word;
    logic [13:0] r5_yc;
    logic [7:0]  r5_qc;

    t_seq        r6_seq;

    logic [22:0] n_xf;
    logic [20:0] n_yf;
    logic [38:0] n_prod_f;
    logic [40:0] n_prod_r;
    logic [21:0] n_rf;
    logic [23:0] n_rr;
    logic [15:0] n_d16;
    logic [15:0] n_word;
    logic [16:0] n_cut;
    logic [17:0] n_cut_rnd;
    logic [31:0] n_prod_c;
    logic [15:0] n_rc;
    logic [7:0]  n_qc;
    logic [7:0]  n_code;
    t_seq        n_seq;

    always_comb begin
        en[5] = !r_v[5] || i_ready;
        for (int k = 4; k >= 0; k--) begin
            en[k] = !r_v[k] || en[k+1];
        end
    end

    assign i_in.ready = en[0];
    assign o_valid    = r_v[5];
    assign o_seq      = r6_seq;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            if (en[0]) r_v[0] <= i_in.valid;
            for (int k = 1; k < 6; k++) begin
                if (en[k]) r_v[k] <= r_v[k-1];
            end
        end
    end

    always_comb begin
        n_xf = 23'(i_in.frequency_khz) + 23'(i_cfg.fine_step ? ROUND_HALF : ROUND_FULL);
        n_yf = i_cfg.fine_step ? n_xf[22:2] : {1'b0, n_xf[22:3]};

        n_prod_f = 39'(r1_yf) * 39'(RECIP_125);
        n_prod_r = 41'(r1_yr) * 41'(RECIP_125);

        n_rf = 22'(r2_yf) - 22'(r2_qf) * 22'd125;
        n_rr = 24'(r2_yr) - 24'(r2_qr) * 24'd125;

        n_d16  = 16'(r3_d);
        n_word = r3_band[4] ? (({n_d16[14:0], 1'b0} & 16'hffe0) | (n_d16 & 16'h000f))
                            : n_d16;
        n_cut  = i_cfg.cutoff_from_rate ? r3_cr : 17'(i_cfg.cutoff_khz);
        if (n_cut == 17'd0) begin
            n_cut = CUTOFF_FALLBACK;
        end
        n_cut_rnd = 18'(n_cut) + CUTOFF_ROUND;

        n_prod_c = 32'(r4_yc) * 32'(RECIP_125);

        n_rc   = 16'(r5_yc) - 16'(r5_qc) * 16'd125;
        n_qc   = r5_qc + 8'(n_rc >= 16'd125);
        n_code = n_qc - 8'd2;

        n_seq.command = r5_cmd;
        n_seq.bytes   = '0;
        if (r5_cmd == CMD_INIT) begin
            n_seq.bytes[7:0]  = BYTE_INIT_0 | 8'(i_cfg.fine_step);
            n_seq.bytes[15:8] = BYTE_INIT_1;
        end else begin
            n_seq.bytes[7:0]   = BYTE_PLL_HI | r5_word[15:8];
            n_seq.bytes[15:8]  = r5_word[7:0];
            n_seq.bytes[23:16] = BYTE_CTRL | 8'(i_cfg.fine_step);
            n_seq.bytes[31:24] = r5_band;
            n_seq.bytes[39:32] = BYTE_LPF_CTRL | 8'(i_cfg.fine_step);
            n_seq.bytes[47:40] = BYTE_LPF_CTRL | {3'd0, n_code[3:2], 3'd0}
                                 | 8'(i_cfg.fine_step);
            n_seq.bytes[55:48] = r5_band | {4'd0, n_code[1:0], 2'd0};
            n_seq.bytes[63:56] = 8'd0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en[0]) begin
            r1_cmd  <= i_in.command;
            r1_band <= band_lookup(i_in.frequency_khz);
            r1_yf   <= n_yf;
            r1_yr   <= i_in.rate_sps[RATE_W-1:3];
        end
        if (en[1]) begin
            r2_cmd  <= r1_cmd;
            r2_band <= r1_band;
            r2_yf   <= r1_yf;
            r2_yr   <= r1_yr;
            r2_qf   <= n_prod_f[38:RECIP_SHIFT];
            r2_qr   <= n_prod_r[40:RECIP_SHIFT];
        end
        if (en[2]) begin
            r3_cmd  <= r2_cmd;
            r3_band <= r2_band;
            r3_d    <= r2_qf + 15'(n_rf >= 22'd125);
            r3_cr   <= r2_qr + 17'(n_rr >= 24'd125);
        end
        if (en[3]) begin
            r4_cmd  <= r3_cmd;
            r4_band <= r3_band;
            r4_word <= n_word;
            r4_yc   <= n_cut_rnd[17:4];
        end
        if (en[4]) begin
            r5_cmd  <= r4_cmd;
            r5_band <= r4_band;
            r5_word <= r4_word;
            r5_yc   <= r4_yc;
            r5_qc   <= n_prod_c[31:RECIP_SHIFT];
        end
        if (en[5]) begin
            r6_seq  <= n_seq;
        end
    end

endmodule

// ===== rtl/core/tpcs_serial.sv =====
// Output serialiser: holds one command's byte set and hands out one byte per
// transaction with its transfer tags. Depends on tpcs_pkg and tpcs_if.
module tpcs_serial (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    output logic            o_ready,
    input  tpcs_pkg::t_seq  i_seq,
    tpcs_out_if.source      o_out
);
    import tpcs_pkg::*;

    logic                 r_busy;
    logic [IDX_W-1:0]     r_idx;
    logic                 r_cmd;
    logic [SEQ_LEN*8-1:0] r_bytes;

    logic             n_take;
    logic             n_done;
    logic [IDX_W-1:0] n_last_idx;
    t_meta            n_meta;

    assign n_last_idx = (r_cmd == CMD_TUNE) ? LAST_IDX_TUNE : LAST_IDX_INIT;
    assign n_take     = r_busy && o_out.ready;
    assign n_done     = n_take && (r_idx == n_last_idx);
    assign o_ready    = !r_busy || n_done;
    assign n_meta     = seq_meta(r_cmd, r_idx);

    assign o_out.valid             = r_busy;
    assign o_out.data_byte         = r_bytes[r_idx*8 +: 8];
    assign o_out.transfer_number   = n_meta.transfer_number;
    assign o_out.first_of_transfer = n_meta.first_of_transfer;
    assign o_out.is_read           = n_meta.is_read;
    assign o_out.wait_after        = n_meta.wait_after;
    assign o_out.last              = n_meta.last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_idx  <= '0;
        end else if (i_valid && o_ready) begin
            r_busy <= 1'b1;
            r_idx  <= '0;
        end else if (n_done) begin
            r_busy <= 1'b0;
        end else if (n_take) begin
            r_idx  <= r_idx + 3'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_cmd   <= i_seq.command;
            r_bytes <= i_seq.bytes;
        end
    end

endmodule

// ===== rtl/core/tuner_pll_command_sequencer_unit.sv =====
// Tuner PLL command sequencer, top level. A command passes the six pipeline registers
// and the serialiser's byte register before its first byte. Throughput: one byte per cycle
// while the output is ready, set by the serialiser: eight bytes per tune, two per init.
// The six-stage pipeline accepts a command each cycle while not stalled.
// Synchronous active-low reset clears the valid bits and returns the
// configuration to its reset values. Depends on tpcs_pkg, tpcs_if, tpcs_pipe and tpcs_serial.
module tuner_pll_command_sequencer_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    tpcs_cfg_if.sink    i_cfg,
    tpcs_in_if.sink     i_in,
    tpcs_out_if.source  o_out
);
    import tpcs_pkg::*;

    t_cfg  r_cfg;
    logic  pipe_valid;
    logic  ser_ready;
    t_seq  pipe_seq;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.fine_step        <= 1'b0;
            r_cfg.cutoff_from_rate <= 1'b1;
            r_cfg.cutoff_khz       <= '0;
        end else if (i_cfg.valid) begin
            unique case (i_cfg.index)
                CFG_FINE_STEP:   r_cfg.fine_step        <= i_cfg.data[0];
                CFG_CUTOFF_RATE: r_cfg.cutoff_from_rate <= i_cfg.data[0];
                CFG_CUTOFF_KHZ:  r_cfg.cutoff_khz       <= i_cfg.data;
                default:         r_cfg                  <= r_cfg;
            endcase
        end
    end

    tpcs_pipe u_pipe (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (r_cfg),
        .i_in    (i_in),
        .o_valid (pipe_valid),
        .i_ready (ser_ready),
        .o_seq   (pipe_seq)
    );

    tpcs_serial u_serial (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (pipe_valid),
        .o_ready (ser_ready),
        .i_seq   (pipe_seq),
        .o_out   (o_out)
    );

    a_seq_continues: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.ready && !o_out.last) |=> o_out.valid)
        else $error("Sequence broke off before its last byte.");

    a_seq_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.ready && o_out.last) |=>
        (!o_out.valid || (o_out.first_of_transfer && o_out.transfer_number == 2'd0)))
        else $error("New sequence does not start with transfer zero.");

    a_read_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.is_read) |-> (o_out.last && o_out.data_byte == 8'd0))
        else $error("Read slot is not the final empty byte.");

endmodule

// ===== sim/tuner_pll_command_sequencer_unit_test.sv =====
// Self-checking testbench of the tuner PLL command sequencer: it predicts the bus
// byte sequence of every command and compares each output transaction field by field.
// Depends on tpcs_pkg, the tpcs channel interfaces and tuner_pll_command_sequencer_unit.
module tuner_pll_command_sequencer_unit_test;
    import tpcs_pkg::*;

    localparam int CYCLE_LIMIT  = 400000;
    localparam int DRAIN_CYCLES = 16;
    localparam int HOLD_CYCLES  = 400;
    localparam int MAX_PRINTED  = 40;

    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

    localparam int unsigned PLL_STEP_KHZ = 1000;
    localparam int unsigned RATE_PER_KHZ = 1000;
    localparam int unsigned LPF_UNIT     = 2000;
    localparam int unsigned LPF_FALLBACK = 30000;

    localparam logic [7:0] INIT_HEAD = 8'hf8;
    localparam logic [7:0] INIT_TAIL = 8'h04;
    localparam logic [7:0] PLL_HEAD  = 8'h40;
    localparam logic [7:0] CTRL_BASE = 8'he0;
    localparam logic [7:0] LPF_BASE  = 8'he4;
    localparam logic [7:0] TOP_BAND  = 8'hc0;
    localparam logic [7:0] PRESCALE  = 8'h10;

    localparam logic [FREQ_W-1:0] EDGE_KHZ [8] = '{
        22'd986000, 22'd1072000, 22'd1154000, 22'd1291000,
        22'd1447000, 22'd1615000, 22'd1791000, 22'd1972000
    };
    localparam logic [7:0] EDGE_BAND [8] = '{
        8'hb2, 8'hd2, 8'he2, 8'h20, 8'h40, 8'h60, 8'h80, 8'ha0
    };
    localparam int unsigned LPF_RATES [8] = '{
        2000000, 2001000, 999, 1000, 4000999, 4001000, 27500000, 45000000
    };

    typedef struct packed {
        logic              command;
        logic [FREQ_W-1:0] freq_khz;
        logic [RATE_W-1:0] sym_rate;
    } t_tune_req;

    typedef struct packed {
        logic [7:0] data;
        logic [1:0] xfer;
        logic       first;
        logic       rd;
        logic       wt;
        logic       lst;
    } t_bus_byte;

    logic i_clk;
    logic i_rst_n;

    tpcs_cfg_if cfg_ch ();
    tpcs_in_if  cmd_ch ();
    tpcs_out_if byte_ch ();

    tuner_pll_command_sequencer_unit dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (cfg_ch),
        .i_in    (cmd_ch),
        .o_out   (byte_ch)
    );

    t_tune_req cmd_pending [$];
    t_bus_byte bytes_due [$];

    logic        shadow_half;
    logic        shadow_from_rate;
    logic [15:0] shadow_cutoff;

    int   idle_pct;
    int   stall_pct;
    logic hold_off;
    logic cmd_taken;
    int   err_count;
    int   cycle_count;

    always begin
        i_clk = 1'b0;
        #6;
        i_clk = 1'b1;
        #6;
    end

    task automatic report_mismatch(input string what);
        err_count++;
        if (err_count <= MAX_PRINTED) begin
            $display("mismatch at cycle %0d: %s", cycle_count, what);
        end
    endtask

    function automatic void queue_byte(input logic [7:0] d, input logic [1:0] x,
                                       input logic f, input logic r, input logic w,
                                       input logic l);
        t_bus_byte b;
        b = '{data: d, xfer: x, first: f, rd: r, wt: w, lst: l};
        bytes_due.push_back(b);
    endfunction

    function automatic void predict_sequence(input t_tune_req req);
        int unsigned step;
        int unsigned word;
        int unsigned cutoff;
        int unsigned code;
        logic [7:0]  band;
        logic        found;
        if (req.command == CMD_INIT) begin
            queue_byte(INIT_HEAD | 8'(shadow_half), 2'd0, 1'b1, 1'b0, 1'b0, 1'b0);
            queue_byte(INIT_TAIL, 2'd0, 1'b0, 1'b0, 1'b0, 1'b1);
        end else begin
            step = shadow_half ? PLL_STEP_KHZ / 2 : PLL_STEP_KHZ;
            word = ((req.freq_khz + step / 2) / step) & 32'hffff;
            band = TOP_BAND;
            found = 1'b0;
            for (int i = 0; i < 8; i++) begin
                if (!found && req.freq_khz < EDGE_KHZ[i]) begin
                    band = EDGE_BAND[i];
                    found = 1'b1;
                end
            end
            if ((band & PRESCALE) != 8'h00) begin
                word = (((word << 1) & ~32'h1f) | (word & 32'h0f)) & 32'hffff;
            end
            queue_byte(8'(PLL_HEAD | (word >> 8)), 2'd0, 1'b1, 1'b0, 1'b0, 1'b0);
            queue_byte(8'(word), 2'd0, 1'b0, 1'b0, 1'b0, 1'b0);
            queue_byte(CTRL_BASE | 8'(shadow_half), 2'd0, 1'b0, 1'b0, 1'b0, 1'b0);
            queue_byte(band, 2'd0, 1'b0, 1'b0, 1'b0, 1'b0);
            queue_byte(LPF_BASE | 8'(shadow_half), 2'd1, 1'b1, 1'b0, 1'b1, 1'b0);
            cutoff = shadow_from_rate ? req.sym_rate / RATE_PER_KHZ : shadow_cutoff;
            if (cutoff == 0) begin
                cutoff = LPF_FALLBACK;
            end
            code = ((cutoff + LPF_UNIT - 1) / LPF_UNIT - 2) & 32'hff;
            queue_byte(8'(LPF_BASE | ((code & 32'h0c) << 1) | shadow_half),
                       2'd2, 1'b1, 1'b0, 1'b0, 1'b0);
            queue_byte(8'(band | ((code & 32'h03) << 2)), 2'd2, 1'b0, 1'b0, 1'b0, 1'b0);
            queue_byte(8'h00, 2'd3, 1'b1, 1'b1, 1'b0, 1'b1);
        end
    endfunction

    function automatic t_tune_req random_request();
        t_tune_req   r;
        int unsigned pick;
        r.command = ($urandom_range(3) == 0) ? CMD_INIT : CMD_TUNE;
        pick = $urandom_range(9);
        if (pick < 5) begin
            r.freq_khz = 22'($urandom_range(2100000, 900000));
        end else if (pick < 7) begin
            r.freq_khz = 22'(EDGE_KHZ[$urandom_range(7)] + $urandom_range(4) - 2);
        end else begin
            r.freq_khz = 22'($urandom_range(4194303));
        end
        pick = $urandom_range(9);
        if (pick < 5) begin
            r.sym_rate = 26'($urandom_range(45000000, 1000000));
        end else if (pick < 6) begin
            r.sym_rate = 26'($urandom_range(4100000));
        end else begin
            r.sym_rate = 26'($urandom());
        end
        return r;
    endfunction

    // The command driver offers the next pending command once the previous one
    // has gone, or idles at the rate of the current phase.
    always @(negedge i_clk) begin
        t_tune_req req;
        if (!i_rst_n) begin
            cmd_ch.valid <= 1'b0;
        end else if (!cmd_ch.valid || cmd_taken) begin
            if (cmd_pending.size() != 0 && $urandom_range(99) >= idle_pct) begin
                req = cmd_pending.pop_front();
                cmd_ch.valid         <= 1'b1;
                cmd_ch.command       <= req.command;
                cmd_ch.frequency_khz <= req.freq_khz;
                cmd_ch.rate_sps      <= req.sym_rate;
            end else begin
                cmd_ch.valid <= 1'b0;
            end
        end
    end

    always @(negedge i_clk) begin
        byte_ch.ready <= i_rst_n && !hold_off && ($urandom_range(99) >= stall_pct);
    end

    always @(posedge i_clk) begin
        t_tune_req req;
        t_bus_byte got;
        t_bus_byte want;
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", CYCLE_LIMIT);
            $display("** tuner_pll_command_sequencer_unit: FAILED **");
            $finish;
        end else begin
            cmd_taken = i_rst_n && cmd_ch.valid && cmd_ch.ready;
            if (cmd_taken) begin
                req = '{command: cmd_ch.command, freq_khz: cmd_ch.frequency_khz,
                        sym_rate: cmd_ch.rate_sps};
                predict_sequence(req);
            end
            if (i_rst_n && byte_ch.valid && byte_ch.ready) begin
                got = '{data: byte_ch.data_byte, xfer: byte_ch.transfer_number,
                        first: byte_ch.first_of_transfer, rd: byte_ch.is_read,
                        wt: byte_ch.wait_after, lst: byte_ch.last};
                if (bytes_due.size() == 0) begin
                    report_mismatch($sformatf("unexpected transaction, byte %02h", got.data));
                end else begin
                    want = bytes_due.pop_front();
                    if (got.data != want.data)
                        report_mismatch($sformatf("data_byte %02h, expected %02h",
                                                  got.data, want.data));
                    if (got.xfer != want.xfer)
                        report_mismatch($sformatf("transfer_number %0d, expected %0d",
                                                  got.xfer, want.xfer));
                    if (got.first != want.first)
                        report_mismatch($sformatf("first_of_transfer %0b, expected %0b",
                                                  got.first, want.first));
                    if (got.rd != want.rd)
                        report_mismatch($sformatf("is_read %0b, expected %0b",
                                                  got.rd, want.rd));
                    if (got.wt != want.wt)
                        report_mismatch($sformatf("wait_after %0b, expected %0b",
                                                  got.wt, want.wt));
                    if (got.lst != want.lst)
                        report_mismatch($sformatf("last %0b, expected %0b",
                                                  got.lst, want.lst));
                end
            end
        end
    end

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] value);
        @(negedge i_clk);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= value;
        do @(posedge i_clk); while (!cfg_ch.ready);
        case (idx)
            CFG_FINE_STEP: begin
                shadow_half = value[0];
            end
            CFG_CUTOFF_RATE: begin
                shadow_from_rate = value[0];
            end
            CFG_CUTOFF_KHZ: begin
                shadow_cutoff = value;
            end
            default: begin
            end
        endcase
        @(negedge i_clk);
        cfg_ch.valid <= 1'b0;
    endtask

    // Queues the random part of a phase, then waits until every expected byte
    // has been seen and the pipeline has had time to settle.
    task automatic run_phase(input int idle, input int stall, input int count,
                             input bit pressure);
        @(posedge i_clk);
        idle_pct  = idle;
        stall_pct = stall;
        repeat (count) cmd_pending.push_back(random_request());
        if (pressure) begin
            fork
                begin
                    hold_off = 1'b1;
                    repeat (HOLD_CYCLES) @(posedge i_clk);
                    hold_off = 1'b0;
                end
            join_none
        end
        do @(posedge i_clk);
        while (cmd_pending.size() != 0 || cmd_ch.valid || bytes_due.size() != 0 || hold_off);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    initial begin
        t_tune_req req;
        i_rst_n              = 1'b0;
        cmd_ch.valid         = 1'b0;
        cmd_ch.command       = CMD_INIT;
        cmd_ch.frequency_khz = '0;
        cmd_ch.rate_sps      = '0;
        byte_ch.ready        = 1'b0;
        cfg_ch.valid         = 1'b0;
        cfg_ch.index         = CFG_FINE_STEP;
        cfg_ch.data          = '0;
        hold_off             = 1'b0;
        idle_pct             = 0;
        stall_pct            = 0;
        cmd_taken            = 1'b0;
        err_count            = 0;
        cycle_count          = 0;
        shadow_half          = 1'b0;
        shadow_from_rate     = 1'b1;
        shadow_cutoff        = '0;
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed commands under the reset configuration: both commands, field
        // extremes, the divider rounding edge, both sides of every band threshold,
        // and symbol rates at the edges of the low-pass code and the fallback.
        @(posedge i_clk);
        cmd_pending.push_back('{command: CMD_INIT, freq_khz: '0, sym_rate: '0});
        cmd_pending.push_back('{command: CMD_INIT, freq_khz: '1, sym_rate: '1});
        cmd_pending.push_back('{command: CMD_TUNE, freq_khz: '0, sym_rate: '0});
        cmd_pending.push_back('{command: CMD_TUNE, freq_khz: '1, sym_rate: '1});
        cmd_pending.push_back('{command: CMD_TUNE, freq_khz: 22'd1499, sym_rate: 26'd999999});
        cmd_pending.push_back('{command: CMD_TUNE, freq_khz: 22'd1500, sym_rate: 26'd1000000});
        for (int i = 0; i < 8; i++) begin
            req = '{command: CMD_TUNE, freq_khz: 22'(EDGE_KHZ[i] - 1),
                    sym_rate: 26'(LPF_RATES[i])};
            cmd_pending.push_back(req);
            req = '{command: CMD_TUNE, freq_khz: EDGE_KHZ[i],
                    sym_rate: 26'(LPF_RATES[7 - i])};
            cmd_pending.push_back(req);
        end
        run_phase(0, 0, 0, 1'b0);

        write_reg(CFG_FINE_STEP, 16'hffff);
        write_reg(CFG_CUTOFF_RATE, 16'hfffe);
        write_reg(CFG_CUTOFF_KHZ, 16'h0000);
        write_reg(CFG_UNUSED, 16'($urandom()));
        run_phase(70, 0, 90, 1'b0);

        write_reg(CFG_FINE_STEP, 16'h0002);
        write_reg(CFG_CUTOFF_KHZ, 16'hffff);
        run_phase(0, 70, 90, 1'b0);

        write_reg(CFG_FINE_STEP, 16'h0001);
        write_reg(CFG_CUTOFF_RATE, 16'hfffd);
        write_reg(CFG_CUTOFF_KHZ, 16'($urandom()));
        run_phase(10, 10, 90, 1'b0);

        write_reg(CFG_FINE_STEP, 16'h0000);
        write_reg(CFG_CUTOFF_RATE, 16'h0000);
        write_reg(CFG_CUTOFF_KHZ, 16'($urandom_range(4001, 1)));
        run_phase(0, 0, 90, 1'b1);

        write_reg(CFG_FINE_STEP, 16'($urandom_range(1)));
        write_reg(CFG_CUTOFF_RATE, 16'h0001);
        write_reg(CFG_CUTOFF_KHZ, 16'($urandom()));
        run_phase(0, 0, 90, 1'b0);

        if (err_count == 0) begin
            $display("** tuner_pll_command_sequencer_unit: PASSED **");
        end else begin
            $display("** tuner_pll_command_sequencer_unit: FAILED **");
        end
        $finish;
    end

endmodule
